FILE: rtl/audio_mix_accumulate_and_output_assert.svh
// Assertion macros for the mix accumulator block.
// Depends on nothing; included by the top level only.
`ifndef AUDIO_MIX_ACCUMULATE_AND_OUTPUT_ASSERT_SVH
`define AUDIO_MIX_ACCUMULATE_AND_OUTPUT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AMAO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("amao assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AMAO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("amao assertion failed");

`endif

FILE: rtl/amao_pkg.sv
// Shared types, constants and output formatting for the mix accumulator.
// Depends on nothing; used by amao_emit, the top level and the testbench.
package amao_pkg;

   localparam int SUM_W  = 32;
   localparam int PROD_W = 41;
   localparam int IDX_W  = 16;
   localparam int SMP_W  = 16;

   localparam logic signed [SMP_W-1:0] SAT_MAX  = 16'sh7fff;
   localparam logic signed [SMP_W-1:0] SAT_MIN  = 16'sh8000;
   localparam logic [7:0]              OFFSET_8 = 8'd128;

   // CSR register indexes
   localparam logic [2:0] CSR_MASTER_VOLUME = 3'd0;
   localparam logic [2:0] CSR_RING_LOG2     = 3'd1;
   localparam logic [2:0] CSR_STEREO        = 3'd2;
   localparam logic [2:0] CSR_SIXTEEN       = 3'd3;

   // One emit request: both scaled sums plus ring positions and format flags.
   typedef struct packed {
      logic signed [PROD_W-1:0] prod_l;
      logic signed [PROD_W-1:0] prod_r;
      logic [IDX_W-1:0]         idx_l;
      logic [IDX_W-1:0]         idx_r;
      logic                     stereo;
      logic                     sixteen;
   } emit_req_type;

   // Shift a master-scaled sum down by 8, saturate, and format the sample.
   function automatic logic [SMP_W-1:0] format_sample(input logic signed [PROD_W-1:0] prod,
                                                      input logic sixteen);
      logic signed [PROD_W-9:0] v;
      logic signed [SMP_W-1:0]  sat;
      v = prod[PROD_W-1:8];
      if (v > (PROD_W-8)'(SAT_MAX)) begin
         sat = SAT_MAX;
      end else if (v < (PROD_W-8)'(SAT_MIN)) begin
         sat = SAT_MIN;
      end else begin
         sat = v[SMP_W-1:0];
      end
      if (sixteen) begin
         return sat;
      end
      return {8'h00, sat[SMP_W-1:8] + OFFSET_8};
   endfunction

endpackage

FILE: rtl/audio_mix_accumulate_and_output.sv
// Top level of the stereo mix accumulator with volume scaling and saturating output.
// Depends on amao_pkg, amao_ram, amao_emit and the assertion macro header.
// Usage:
//  - Request channel (req_valid / req_stall): a paint request adds one scaled
//    sample to a slot's left and right sums; an emit request reads a slot,
//    clears it, and produces one (mono) or two (stereo, left then right)
//    results on the response channel (rsp_valid / rsp_stall).
//  - CSR channel (csr_valid / csr_ready, always ready): write master volume,
//    ring size, stereo and 16-bit flags while the block is idle.
//  - Slot sums live in one 64-bit wide synchronous RAM (left high, right low).
//    A request reads its slot on accept, modifies it the next cycle and writes
//    back; a one-entry forward register covers a back-to-back hit on the same slot.
//  - Paint requests go one per cycle while req_stall is low. An emit holds off new
//    requests until its last result is loaded into the output register by the
//    single emit holding stage. The first result of an emit passes the modify stage,
//    then the emit holding stage, then the output register.
//  - Reset: a clearing pass writes zero into every slot, one per cycle, while
//    req_stall stays high. CSRs return to defaults.
//  - Receiver stall: the output register holds its result; one further emit
//    can be accepted and parked in the emit stage while the result waits.
module audio_mix_accumulate_and_output
   import amao_pkg::*;
#(
   parameter int SLOT_COUNT = 2048
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [10:0]        req_slot_index,
   input  logic signed [15:0] req_sample_value,
   input  logic               req_sample_is_16bit,
   input  logic [7:0]         req_left_volume,
   input  logic [7:0]         req_right_volume,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample,
   output logic [15:0]        rsp_out_index,
   output logic               rsp_is_right,
   output logic               rsp_last,
   // CSR write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [8:0]         csr_data
);

   `include "audio_mix_accumulate_and_output_assert.svh"

   localparam int AW = $clog2(SLOT_COUNT);

   // Scale one source sample by a channel gain.
   function automatic logic [SUM_W-1:0] paint_amount(input logic signed [15:0] s,
                                                     input logic wide,
                                                     input logic [7:0] vol);
      logic signed [7:0]  s8;
      logic signed [24:0] p16;
      logic signed [13:0] p8;
      s8  = s[7:0];
      p16 = s * $signed({1'b0, vol});
      p8  = s8 * $signed({1'b0, vol[7:3]});
      if (wide) begin
         return SUM_W'(p16 >>> 8);
      end
      return SUM_W'(p8) << 3;
   endfunction

   // CSRs
   logic [8:0]  master_ff, master_in;
   logic [4:0]  ring_log2_ff, ring_log2_in;
   logic        stereo_ff, stereo_in;
   logic        sixteen_ff, sixteen_in;

   // clearing pass
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // modify stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_emit_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic             s1_in_range_ff;
   logic [SUM_W-1:0] s1_amt_l_ff, s1_amt_r_ff;

   // forward register: last data written by the modify stage
   logic                 fw_valid_ff, fw_valid_in;
   logic [AW-1:0]        fw_addr_ff;
   logic [2*SUM_W-1:0]   fw_data_ff;

   logic [IDX_W-1:0] ring_pos_ff, ring_pos_in;

   logic                 accept;
   logic                 req_in_range;
   logic [AW-1:0]        req_addr;
   logic [2*SUM_W-1:0]   ram_rdata;
   logic [2*SUM_W-1:0]   cur_sums;
   logic [SUM_W-1:0]     sum_l, sum_r;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [2*SUM_W-1:0]   ram_wr_data;
   logic [2*SUM_W-1:0]   mod_data;
   logic                 mod_wr;
   logic                 emit_valid;
   logic                 emit_busy;
   emit_req_type         emit_req;
   logic [4:0]           ring_lg;
   logic [IDX_W-1:0]     ring_mask;
   logic [IDX_W-1:0]     idx_l;

   assign req_in_range = 17'(req_slot_index) < 17'(SLOT_COUNT);
   assign req_addr     = AW'(req_slot_index);
   assign req_stall    = clearing_ff || emit_busy || (s1_valid_ff && s1_emit_ff);
   assign accept       = req_valid && !req_stall;
   assign csr_ready    = 1'b1;

   // CSR decode
   always_comb begin
      master_in    = master_ff;
      ring_log2_in = ring_log2_ff;
      stereo_in    = stereo_ff;
      sixteen_in   = sixteen_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MASTER_VOLUME: master_in    = csr_data;
            CSR_RING_LOG2:     ring_log2_in = csr_data[4:0];
            CSR_STEREO:        stereo_in    = csr_data[0];
            CSR_SIXTEEN:       sixteen_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   // Read data, with forwarding of a write to the same slot in the prior cycle.
   always_comb begin
      cur_sums = (fw_valid_ff && fw_addr_ff == s1_addr_ff) ? fw_data_ff : ram_rdata;
      if (!s1_in_range_ff) begin
         cur_sums = '0;
      end
      sum_l = cur_sums[2*SUM_W-1:SUM_W];
      sum_r = cur_sums[SUM_W-1:0];
   end

   // Modify: accumulate for paint, zero for emit; drop out-of-range slots.
   assign mod_wr   = s1_valid_ff && s1_in_range_ff;
   assign mod_data = s1_emit_ff ? '0 : {sum_l + s1_amt_l_ff, sum_r + s1_amt_r_ff};

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = mod_wr;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = mod_data;
      end
   end

   // Ring positions for an emit.
   always_comb begin
      ring_lg   = (ring_log2_ff > 5'd16) ? 5'd16 : ring_log2_ff;
      ring_mask = IDX_W'((17'd1 << ring_lg) - 17'd1);
      idx_l     = (stereo_ff ? {ring_pos_ff[IDX_W-2:0], 1'b0} : ring_pos_ff) & ring_mask;
   end

   assign emit_valid       = s1_valid_ff && s1_emit_ff;
   assign emit_req.prod_l  = $signed(sum_l) * $signed({1'b0, master_ff});
   assign emit_req.prod_r  = $signed(sum_r) * $signed({1'b0, master_ff});
   assign emit_req.idx_l   = idx_l;
   assign emit_req.idx_r   = (idx_l + IDX_W'(1)) & ring_mask;
   assign emit_req.stereo  = stereo_ff;
   assign emit_req.sixteen = sixteen_ff;

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(SLOT_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
      s1_valid_in = accept;
      fw_valid_in = clearing_ff ? 1'b0 : (mod_wr ? 1'b1 : fw_valid_ff);
      ring_pos_in = emit_valid ? ring_pos_ff + IDX_W'(1) : ring_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= 9'd256;
         ring_log2_ff <= 5'd14;
         stereo_ff    <= 1'b1;
         sixteen_ff   <= 1'b1;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         ring_pos_ff  <= '0;
      end else begin
         master_ff    <= master_in;
         ring_log2_ff <= ring_log2_in;
         stereo_ff    <= stereo_in;
         sixteen_ff   <= sixteen_in;
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fw_valid_ff  <= fw_valid_in;
         ring_pos_ff  <= ring_pos_in;
      end
      if (accept) begin
         s1_emit_ff     <= req_action;
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
         s1_amt_l_ff    <= paint_amount(req_sample_value, req_sample_is_16bit, req_left_volume);
         s1_amt_r_ff    <= paint_amount(req_sample_value, req_sample_is_16bit, req_right_volume);
      end
      if (mod_wr) begin
         fw_addr_ff <= s1_addr_ff;
         fw_data_ff <= mod_data;
      end
   end

   amao_ram #(
      .WIDTH(2 * SUM_W),
      .DEPTH(SLOT_COUNT)
   ) u_sums (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (accept),
      .rd_addr(req_addr),
      .rd_data(ram_rdata)
   );

   amao_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .emit_valid    (emit_valid),
      .emit_req      (emit_req),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_sample(rsp_out_sample),
      .rsp_out_index (rsp_out_index),
      .rsp_is_right  (rsp_is_right),
      .rsp_last      (rsp_last)
   );

   // The emit stage must be free whenever an emit leaves the modify stage.
   `AMAO_ASSERT_NOW(a_emit_slot_free, clock, reset, emit_valid, !emit_busy)
   // No request is in flight during the clearing pass.
   `AMAO_ASSERT_NOW(a_no_work_while_clearing, clock, reset, clearing_ff, !s1_valid_ff)
   // A right-channel result always closes its emit.
   `AMAO_ASSERT_NOW(a_right_is_last, clock, reset, rsp_valid && rsp_is_right, rsp_last)
   // An accepted emit blocks the next request in the following cycle.
   `AMAO_ASSERT_NEXT(a_emit_blocks, clock, reset, accept && req_action, req_stall)

endmodule

FILE: rtl/amao_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module amao_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/amao_emit.sv
// Emit stage: holds one emit request and drives results into the output register.
// Depends on amao_pkg for the request type and sample formatting.
module amao_emit
   import amao_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               emit_valid,
   input  emit_req_type       emit_req,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SMP_W-1:0]   rsp_out_sample,
   output logic [IDX_W-1:0]   rsp_out_index,
   output logic               rsp_is_right,
   output logic               rsp_last
);

   logic               c_valid_ff, c_valid_in;
   logic               c_right_ff, c_right_in;
   emit_req_type       c_ff, c_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]   sample_ff, sample_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic               right_ff, right_in;
   logic               last_ff, last_in;
   logic               load;

   // Move the held channel into the output register when it is free or draining.
   assign load = c_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      c_valid_in   = c_valid_ff;
      c_right_in   = c_right_ff;
      c_in         = c_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      index_in     = index_ff;
      right_in     = right_ff;
      last_in      = last_ff;
      if (emit_valid) begin
         c_valid_in = 1'b1;
         c_right_in = 1'b0;
         c_in       = emit_req;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         sample_in    = format_sample(c_right_ff ? c_ff.prod_r : c_ff.prod_l, c_ff.sixteen);
         index_in     = c_right_ff ? c_ff.idx_r : c_ff.idx_l;
         right_in     = c_right_ff;
         last_in      = c_right_ff || !c_ff.stereo;
         if (c_ff.stereo && !c_right_ff) begin
            c_right_in = 1'b1;
         end else begin
            c_valid_in = 1'b0;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         c_right_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         c_right_ff   <= c_right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff      <= c_in;
      sample_ff <= sample_in;
      index_ff  <= index_in;
      right_ff  <= right_in;
      last_ff   <= last_in;
   end

   assign busy           = c_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = sample_ff;
   assign rsp_out_index  = index_ff;
   assign rsp_is_right   = right_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for audio_mix_accumulate_and_output: directed table, then random.
// Holds its own accumulator/ring predictor; depends on amao_pkg and the block's RTL only.
module tb_top
   import amao_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS         = 2048;
   localparam int SETTLE_CYCLES = 8;     // margin for the emit path and trailing read-modify-writes
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 192;
   localparam int HOT_SLOTS     = 6;

   localparam logic ACT_PAINT = 1'b0;
   localparam logic ACT_EMIT  = 1'b1;

   localparam logic [2:0] CSR_SPARE = 3'd4;   // unmapped, must be ignored

   typedef enum logic {ROW_REQUEST, ROW_CSR_WRITE} row_kind_type;

   typedef struct {
      logic               action;
      logic [10:0]        slot;
      logic signed [15:0] sample;
      logic               wide;
      logic [7:0]         vol_l;
      logic [7:0]         vol_r;
   } mix_req_type;

   typedef struct {
      logic [SMP_W-1:0] sample;
      logic [IDX_W-1:0] index;
      logic             is_right;
      logic             last;
   } mix_result_type;

   // One line of the directed table: a request or a register write, with optional
   // hand-computed samples that replace the predicted ones.
   typedef struct {
      row_kind_type kind;
      mix_req_type  req;
      logic [2:0]   reg_index;
      logic [8:0]   reg_data;
      bit           typed;
      logic [15:0]  typed_l;
      logic [15:0]  typed_r;
   } stim_row_type;

   // ---------------------------------------------------------------- DUT signals
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = 1'b0;
   logic [10:0]        req_slot_index = '0;
   logic signed [15:0] req_sample_value = '0;
   logic               req_sample_is_16bit = 1'b0;
   logic [7:0]         req_left_volume = '0;
   logic [7:0]         req_right_volume = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_sample;
   logic [15:0]        rsp_out_index;
   logic               rsp_is_right;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [8:0]         csr_data = '0;

   audio_mix_accumulate_and_output u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_slot_index      (req_slot_index),
      .req_sample_value    (req_sample_value),
      .req_sample_is_16bit (req_sample_is_16bit),
      .req_left_volume     (req_left_volume),
      .req_right_volume    (req_right_volume),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_sample      (rsp_out_sample),
      .rsp_out_index       (rsp_out_index),
      .rsp_is_right        (rsp_is_right),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest legal run (clearing pass, full stalls, gaps).
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor state
   logic [31:0]      mix_left [SLOTS];
   logic [31:0]      mix_right[SLOTS];
   logic [15:0]      ring_pos;
   logic [8:0]       cfg_master;
   logic [4:0]       cfg_ring_log2;
   logic             cfg_stereo;
   logic             cfg_sixteen;

   mix_result_type   expected_samples[$];
   stim_row_type     directed_rows[$];
   logic [10:0]      hot[HOT_SLOTS];

   int unsigned      errors = 0;
   int unsigned      n_requests = 0;
   int unsigned      n_emits = 0;
   int unsigned      n_checked = 0;
   int unsigned      n_settings = 0;
   int unsigned      burst_left = 0;

   // Gain one source sample into a 32-bit accumulator increment.
   function automatic logic [31:0] paint_gain(logic signed [15:0] sample, logic wide,
                                              logic [7:0] vol);
      logic signed [7:0] byte_s;
      longint            s;
      longint            g;
      longint            r;
      if (wide) begin
         s = longint'(sample);
         g = longint'(vol);
         r = (s * g) >>> 8;     // floor, not truncation toward zero
      end else begin
         byte_s = sample[7:0];  // upper byte carries no weight for 8-bit sources
         s = longint'(byte_s);
         g = longint'(vol >> 3);
         r = s * g * 8;
      end
      return r[31:0];
   endfunction

   // Apply master gain, saturate to 16 bits, then format for the output width.
   function automatic logic [15:0] output_sample(logic [31:0] sum);
      int     s32;
      longint v;
      longint m;
      s32 = sum;
      m   = longint'(cfg_master);
      v   = (longint'(s32) * m) >>> 8;
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      if (!cfg_sixteen) begin
         v = (v >>> 8) + 128;
      end
      return v[15:0];
   endfunction

   // Advance the predictor by one accepted request; queue whatever it yields.
   function automatic void mix_predict(mix_req_type r, bit typed, logic [15:0] tl,
                                       logic [15:0] tr);
      logic [31:0]    mask;
      logic [31:0]    idx;
      logic [31:0]    chans;
      int             lg;
      mix_result_type res;
      if (r.action == ACT_PAINT) begin
         mix_left[r.slot]  = mix_left[r.slot]  + paint_gain(r.sample, r.wide, r.vol_l);
         mix_right[r.slot] = mix_right[r.slot] + paint_gain(r.sample, r.wide, r.vol_r);
         return;
      end
      lg    = (cfg_ring_log2 > 16) ? 16 : int'(cfg_ring_log2);
      mask  = (32'd1 << lg) - 32'd1;
      chans = cfg_stereo ? 32'd2 : 32'd1;
      idx   = ({16'd0, ring_pos} * chans) & mask;

      res.sample   = typed ? tl : output_sample(mix_left[r.slot]);
      res.index    = idx[15:0];
      res.is_right = 1'b0;
      res.last     = !cfg_stereo;
      expected_samples.push_back(res);
      if (cfg_stereo) begin
         idx          = (idx + 32'd1) & mask;
         res.sample   = typed ? tr : output_sample(mix_right[r.slot]);
         res.index    = idx[15:0];
         res.is_right = 1'b1;
         res.last     = 1'b1;
         expected_samples.push_back(res);
      end
      mix_left[r.slot]  = '0;
      mix_right[r.slot] = '0;
      ring_pos          = ring_pos + 16'd1;
   endfunction

   function automatic void note_register(logic [2:0] index, logic [8:0] data);
      case (index)
         CSR_MASTER_VOLUME: cfg_master    = data;
         CSR_RING_LOG2:     cfg_ring_log2 = data[4:0];
         CSR_STEREO:        cfg_stereo    = data[0];
         CSR_SIXTEEN:       cfg_sixteen   = data[0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endfunction

   // ---------------------------------------------------------------- directed table
   function automatic void add_req(logic action, logic [10:0] slot, logic [15:0] sample,
                                   logic wide, logic [7:0] vl, logic [7:0] vr,
                                   bit typed, logic [15:0] tl, logic [15:0] tr);
      stim_row_type row;
      row.kind       = ROW_REQUEST;
      row.req.action = action;
      row.req.slot   = slot;
      row.req.sample = sample;
      row.req.wide   = wide;
      row.req.vol_l  = vl;
      row.req.vol_r  = vr;
      row.reg_index  = '0;
      row.reg_data   = '0;
      row.typed      = typed;
      row.typed_l    = tl;
      row.typed_r    = tr;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [2:0] index, logic [8:0] data);
      stim_row_type row;
      row.kind       = ROW_CSR_WRITE;
      row.req        = '{default: '0};
      row.reg_index  = index;
      row.reg_data   = data;
      row.typed      = 1'b0;
      row.typed_l    = '0;
      row.typed_r    = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void build_directed();
      // emit of an untouched slot right after reset: silence at ring start
      add_req(ACT_EMIT,  11'd0,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'h0000, 16'h0000);
      // full-scale positive twice overflows 16 bits: saturate high
      add_req(ACT_PAINT, 11'd2,    16'h7fff, 1'b1, 8'd255, 8'd0,   1'b0, 16'h0000, 16'h0000);
      add_req(ACT_PAINT, 11'd2,    16'h7fff, 1'b1, 8'd255, 8'd0,   1'b0, 16'h0000, 16'h0000);
      add_req(ACT_EMIT,  11'd2,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'h7fff, 16'h0000);
      // full-scale negative twice: saturate low
      add_req(ACT_PAINT, 11'd3,    16'h8000, 1'b1, 8'd255, 8'd255, 1'b0, 16'h0000, 16'h0000);
      add_req(ACT_PAINT, 11'd3,    16'h8000, 1'b1, 8'd255, 8'd255, 1'b0, 16'h0000, 16'h0000);
      add_req(ACT_EMIT,  11'd3,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'h8000, 16'h8000);
      // 8-bit source: garbage upper byte, gain truncated to multiples of 8
      add_req(ACT_PAINT, 11'd4,    16'h7f80, 1'b0, 8'd255, 8'd7,   1'b0, 16'h0000, 16'h0000);
      add_req(ACT_EMIT,  11'd4,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'h8400, 16'h0000);
      // tiny negative 16-bit product floors to -1, not 0
      add_req(ACT_PAINT, 11'd5,    16'hffff, 1'b1, 8'd1,   8'd0,   1'b0, 16'h0000, 16'h0000);
      add_req(ACT_EMIT,  11'd5,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'hffff, 16'h0000);
      // master gain above unity, highest slot
      add_csr(CSR_MASTER_VOLUME, 9'd511);
      add_req(ACT_PAINT, 11'd2047, 16'h4000, 1'b1, 8'd255, 8'd128, 1'b0, 16'h0000, 16'h0000);
      add_req(ACT_EMIT,  11'd2047, 16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 16'h0000, 16'h0000);
      // 8-bit output: silence becomes mid-scale
      add_csr(CSR_SIXTEEN, 9'h1fe);
      add_req(ACT_EMIT,  11'd7,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'h0080, 16'h0080);
      // mono: one result, left only
      add_csr(CSR_STEREO, 9'd0);
      add_req(ACT_EMIT,  11'd8,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'h0080, 16'h0000);
      // zero-length ring pins every index to 0; oversized ring clamps to 16 bits
      add_csr(CSR_RING_LOG2, 9'd0);
      add_req(ACT_EMIT,  11'd9,    16'h0000, 1'b0, 8'd0,   8'd0,   1'b0, 16'h0000, 16'h0000);
      add_csr(CSR_RING_LOG2, 9'd31);
      add_csr(CSR_MASTER_VOLUME, 9'd0);
      add_csr(CSR_SPARE, 9'h155);
      add_req(ACT_PAINT, 11'd10,   16'h7fff, 1'b1, 8'd255, 8'd255, 1'b0, 16'h0000, 16'h0000);
      add_req(ACT_EMIT,  11'd10,   16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 16'h0080, 16'h0000);
   endfunction

   // ---------------------------------------------------------------- random items
   function automatic logic [7:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic mix_req_type random_request();
      mix_req_type r;
      r.action = ($urandom_range(0, 4) == 0) ? ACT_EMIT : ACT_PAINT;
      // mostly hammer a few slots so sums build up and forwarding gets exercised
      r.slot   = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, HOT_SLOTS - 1)]
                                             : 11'($urandom_range(0, SLOTS - 1));
      case ($urandom_range(0, 9))
         0:       r.sample = 16'sh7fff;
         1:       r.sample = 16'sh8000;
         2:       r.sample = 16'sh0080;
         3:       r.sample = 16'sh007f;
         default: r.sample = 16'($urandom);
      endcase
      r.wide  = 1'($urandom_range(0, 1));
      r.vol_l = pick_gain();
      r.vol_r = pick_gain();
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   // Present one request at the falling edge and hold it until accepted. Bursts of
   // random length alternate with idle gaps; some bursts are long to keep full rate.
   task automatic send_request(mix_req_type r, bit typed, logic [15:0] tl, logic [15:0] tr);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_action          <= r.action;
      req_slot_index      <= r.slot;
      req_sample_value    <= r.sample;
      req_sample_is_16bit <= r.wide;
      req_left_volume     <= r.vol_l;
      req_right_volume    <= r.vol_r;
      do @(posedge clock); while (req_stall);
      mix_predict(r, typed, tl, tr);
      n_requests++;
      if (r.action == ACT_EMIT) n_emits++;
      burst_left--;
   endtask

   // Drop valid, wait out every expected result, then let trailing paints retire.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [8:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      note_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Pick a fresh setting with the extremes well represented.
   task automatic random_setting();
      logic [8:0] gain;
      logic [8:0] ring;
      case ($urandom_range(0, 4))
         0:       gain = 9'd0;
         1:       gain = 9'd256;
         2:       gain = 9'd511;
         default: gain = 9'($urandom_range(0, 511));
      endcase
      case ($urandom_range(0, 5))
         0:       ring = 9'd0;
         1:       ring = 9'd1;
         2:       ring = 9'd16;
         3:       ring = 9'd31;
         default: ring = {4'($urandom), 5'($urandom_range(0, 31))};
      endcase
      write_register(CSR_MASTER_VOLUME, gain);
      write_register(CSR_RING_LOG2, ring);
      write_register(CSR_STEREO, 9'($urandom));
      write_register(CSR_SIXTEEN, 9'($urandom));
      if ($urandom_range(0, 3) == 0) write_register(CSR_SPARE, 9'($urandom));
      n_settings++;
   endtask

   // ---------------------------------------------------------------- receiver stall
   // Switch between no stall, light random stall and heavy stall every so often.
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 9) < 3);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // ---------------------------------------------------------------- result checker
   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual sample %h index %h",
                     $time, rsp_out_sample, rsp_out_index);
         end else begin
            want = expected_samples.pop_front();
            check_field("out_sample", want.sample, rsp_out_sample);
            check_field("out_index", want.index, rsp_out_index);
            check_field("is_right", 16'(want.is_right), 16'(rsp_is_right));
            check_field("last", 16'(want.last), 16'(rsp_last));
            n_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      int unsigned pause_at;
      mix_req_type r;
      foreach (mix_left[i]) begin
         mix_left[i]  = '0;
         mix_right[i] = '0;
      end
      ring_pos      = '0;
      cfg_master    = 9'd256;
      cfg_ring_log2 = 5'd14;
      cfg_stereo    = 1'b1;
      cfg_sixteen   = 1'b1;

      // hold reset, then release on a falling edge; the clearing pass shows as req_stall
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_directed();
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR_WRITE) begin
            drain_block();
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
         end else begin
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].typed_l, directed_rows[i].typed_r);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_block();
         random_setting();
         foreach (hot[i]) hot[i] = 11'($urandom_range(0, SLOTS - 1));
         pause_at = $urandom_range(20, PHASE_ITEMS - 20);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off mid-phase until the block has nothing left in flight
            if (i == pause_at) drain_block();
            r = random_request();
            send_request(r, 1'b0, 16'h0000, 16'h0000);
         end
      end

      drain_block();
      $display("Ran %0d requests (%0d emits) across %0d random register settings;",
               n_requests, n_emits, n_settings);
      $display("checked %0d output samples, %0d mismatches.", n_checked, errors);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
